/* rtl/shpq_pkg.sv */
// ----------------------------------------------------------------------------
// shpq_pkg
// Shared constants of the sorted handle priority queue: field widths,
// operation codes and status codes.
// ----------------------------------------------------------------------------
package shpq_pkg;

    localparam int KEY_W      = 64;
    localparam int HANDLE_W   = 5;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 6;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 88;

    // Operation carried in the input tuser.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

endpackage

/* rtl/shpq_ram.sv */
// ----------------------------------------------------------------------------
// shpq_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module shpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        // The read data holds while re is low.
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/sorted_handle_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// sorted_handle_priority_queue_unit
// Fixed-capacity priority queue kept as a circular doubly linked list over a
// slot table, with a singly linked free list of unused slots.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                    Contents
//  s_axis    in         s_axis_tvalid/s_axis_tready  tuser: operation
//                                                    tdata: key, handle
//  m_axis    out        m_axis_tvalid/m_axis_tready  tuser: status
//                                                    tdata: new_handle, head_valid,
//                                                           head_handle, head_key, count
//
// One item is worked on at a time. An insert into an empty queue links the
// new entry to itself. An insert into a non-empty queue walks back from the
// tail, at most over the entries queued, in a walk loop that reads one slot
// per cycle from the link and key memories until it finds a smaller key or
// reaches the head. A remove relinks the neighbours of its slot unless it
// removes the last entry; a rejected item changes no link.
// After reset a clearing pass over every slot builds the free list in the
// link memory; no item is accepted during it. A stalled result register does
// not block acceptance of the next item; only the final load of a result
// waits for the register to be free.
//
// The link memory holds, per slot, an in-use flag, a next link (wide enough
// to hold CAPACITY, which ends the free list) and a prev link. The key memory
// holds the 64-bit key of each slot. Links are updated by read, modify and
// write back, with each read issued after the write before it has landed,
// so an update always sees the result of the write before it.
// ----------------------------------------------------------------------------
module sorted_handle_priority_queue_unit #(
    parameter int unsigned CAPACITY = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [63:0] key, [68:64] handle, [71:69] zero
    input  logic [shpq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [0] operation
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [4:0] new_handle, [5] head_valid, [10:6] head_handle, [74:11] head_key,
    // [80:75] count, [87:81] zero
    output logic [shpq_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // [1:0] status
    output logic [shpq_pkg::STATUS_W-1:0]    m_axis_tuser
);

    // Slot index width, and width of values that may reach CAPACITY.
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    // Link entry layout: {in_use, next, prev}.
    localparam int LW = 1 + CW + IW;
    localparam logic [IW-1:0] LAST_SLOT = IW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_VAL   = CW'(CAPACITY);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_INS_FREE = 4'd2;
    localparam logic [3:0] S_INS_TAIL = 4'd3;
    localparam logic [3:0] S_WALK     = 4'd4;
    localparam logic [3:0] S_LA_WA    = 4'd5;
    localparam logic [3:0] S_LA_WB    = 4'd6;
    localparam logic [3:0] S_LA_WN    = 4'd7;
    localparam logic [3:0] S_RM_CHK   = 4'd8;
    localparam logic [3:0] S_RM_WP    = 4'd9;
    localparam logic [3:0] S_RM_RN    = 4'd10;
    localparam logic [3:0] S_RM_WN    = 4'd11;
    localparam logic [3:0] S_HKEY     = 4'd12;
    localparam logic [3:0] S_DONE     = 4'd13;

    // Input fields.
    logic                              in_op;
    logic [shpq_pkg::KEY_W-1:0]        in_key;
    logic [shpq_pkg::HANDLE_W-1:0]     in_handle;

    assign in_op     = s_axis_tuser;
    assign in_key    = s_axis_tdata[63:0];
    assign in_handle = s_axis_tdata[68:64];

    // Control state.
    logic [3:0]                    state_reg,     state_next;
    logic [IW-1:0]                 clr_reg,       clr_next;
    logic [CW-1:0]                 free_head_reg, free_head_next;
    logic [IW-1:0]                 head_reg,      head_next;
    logic [CW-1:0]                 count_reg,     count_next;
    logic                          new_head_reg,  new_head_next;
    logic                          m_valid_reg,   m_valid_next;

    // Per-item working registers.
    logic                              op_reg,     op_next;
    logic [shpq_pkg::KEY_W-1:0]        key_reg,    key_next;
    logic [shpq_pkg::STATUS_W-1:0]     status_reg, status_next;
    logic [IW-1:0]                     slot_reg,   slot_next;
    logic [IW-1:0]                     cur_reg,    cur_next;
    logic [IW-1:0]                     tail_reg,   tail_next;
    logic [IW-1:0]                     a_reg,      a_next;
    logic [IW-1:0]                     n_reg,      n_next;
    logic [IW-1:0]                     p_reg,      p_next;
    logic [shpq_pkg::OUT_DATA_W-1:0]   m_data_reg, m_data_next;
    logic [shpq_pkg::STATUS_W-1:0]     m_user_reg, m_user_next;

    // Memory ports.
    logic                          link_we, link_re;
    logic [IW-1:0]                 link_waddr, link_raddr;
    logic [LW-1:0]                 link_wdata, link_rdata;
    logic                          key_we, key_re;
    logic [IW-1:0]                 key_waddr, key_raddr;
    logic [shpq_pkg::KEY_W-1:0]    key_wdata, key_rdata;

    // Fields of the link entry on the read port.
    logic                          rd_use;
    logic [CW-1:0]                 rd_next;
    logic [IW-1:0]                 rd_prev;
    logic [IW-1:0]                 rd_next_idx;

    assign rd_use      = link_rdata[LW-1];
    assign rd_next     = link_rdata[IW +: CW];
    assign rd_prev     = link_rdata[IW-1:0];
    assign rd_next_idx = IW'(rd_next);

    // Result fields as they are loaded into the output register.
    logic                              res_hv;
    logic [shpq_pkg::HANDLE_W-1:0]     res_nh;
    logic [shpq_pkg::HANDLE_W-1:0]     res_hh;
    logic [shpq_pkg::KEY_W-1:0]        res_hk;
    logic [shpq_pkg::COUNT_W-1:0]      res_cnt;

    assign res_hv  = (count_reg != '0);
    assign res_nh  = (op_reg == shpq_pkg::OP_INSERT && status_reg == shpq_pkg::ST_OK)
                     ? shpq_pkg::HANDLE_W'(slot_reg) : '0;
    assign res_hh  = res_hv ? shpq_pkg::HANDLE_W'(head_reg) : '0;
    assign res_hk  = res_hv ? key_rdata : '0;
    assign res_cnt = shpq_pkg::COUNT_W'(count_reg);

    shpq_ram #(
        .WIDTH (LW),
        .DEPTH (CAPACITY)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    shpq_ram #(
        .WIDTH (shpq_pkg::KEY_W),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .re    (key_re),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        free_head_next = free_head_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        new_head_next  = new_head_reg;
        m_valid_next   = m_valid_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        status_next    = status_reg;
        slot_next      = slot_reg;
        cur_next       = cur_reg;
        tail_next      = tail_reg;
        a_next         = a_reg;
        n_next         = n_reg;
        p_next         = p_reg;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;

        link_we    = 1'b0;
        link_waddr = slot_reg;
        link_wdata = '0;
        link_re    = 1'b0;
        link_raddr = slot_reg;
        key_we     = 1'b0;
        key_waddr  = slot_reg;
        key_wdata  = key_reg;
        key_re     = 1'b0;
        key_raddr  = cur_reg;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                // Every slot free, slot i pointing to slot i + 1.
                link_we    = 1'b1;
                link_waddr = clr_reg;
                link_wdata = {1'b0, CW'(clr_reg) + CW'(1), IW'(0)};
                clr_next   = clr_reg + IW'(1);
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next     = in_op;
                    key_next    = in_key;
                    status_next = shpq_pkg::ST_OK;
                    if (in_op == shpq_pkg::OP_REMOVE)
                    begin
                        if (32'(in_handle) >= 32'(CAPACITY))
                        begin
                            status_next = shpq_pkg::ST_BAD;
                            state_next  = S_HKEY;
                        end
                        else
                        begin
                            slot_next  = IW'(in_handle);
                            link_re    = 1'b1;
                            link_raddr = IW'(in_handle);
                            state_next = S_RM_CHK;
                        end
                    end
                    else if (free_head_reg >= CAP_VAL)
                    begin
                        status_next = shpq_pkg::ST_FULL;
                        state_next  = S_HKEY;
                    end
                    else
                    begin
                        // Take the first free slot and store the key there.
                        slot_next  = IW'(free_head_reg);
                        link_re    = 1'b1;
                        link_raddr = IW'(free_head_reg);
                        key_we     = 1'b1;
                        key_waddr  = IW'(free_head_reg);
                        key_wdata  = in_key;
                        state_next = S_INS_FREE;
                    end
                end
            end

            S_INS_FREE:
            begin
                free_head_next = rd_next;
                count_next     = count_reg + CW'(1);
                if (count_reg == '0)
                begin
                    // First entry links to itself and becomes the head.
                    link_we    = 1'b1;
                    link_waddr = slot_reg;
                    link_wdata = {1'b1, CW'(slot_reg), slot_reg};
                    head_next  = slot_reg;
                    state_next = S_HKEY;
                end
                else
                begin
                    new_head_next = 1'b0;
                    link_re       = 1'b1;
                    link_raddr    = head_reg;
                    state_next    = S_INS_TAIL;
                end
            end

            S_INS_TAIL:
            begin
                // The head's prev link is the tail, where the walk starts.
                cur_next   = rd_prev;
                tail_next  = rd_prev;
                link_re    = 1'b1;
                link_raddr = rd_prev;
                key_re     = 1'b1;
                key_raddr  = rd_prev;
                state_next = S_WALK;
            end

            S_WALK:
            begin
                if (key_rdata < key_reg)
                begin
                    // Link after this entry; its link entry stays on the port.
                    a_next     = cur_reg;
                    state_next = S_LA_WA;
                end
                else if (cur_reg == head_reg)
                begin
                    // No smaller key: the new entry goes after the tail and
                    // becomes the head.
                    a_next        = tail_reg;
                    new_head_next = 1'b1;
                    link_re       = 1'b1;
                    link_raddr    = tail_reg;
                    state_next    = S_LA_WA;
                end
                else
                begin
                    cur_next   = rd_prev;
                    link_re    = 1'b1;
                    link_raddr = rd_prev;
                    key_re     = 1'b1;
                    key_raddr  = rd_prev;
                end
            end

            S_LA_WA:
            begin
                link_we    = 1'b1;
                link_waddr = a_reg;
                link_wdata = {1'b1, CW'(slot_reg), rd_prev};
                n_next     = rd_next_idx;
                state_next = S_LA_WB;
            end

            S_LA_WB:
            begin
                // When the successor is the predecessor itself, this read
                // returns the entry just written.
                link_we    = 1'b1;
                link_waddr = slot_reg;
                link_wdata = {1'b1, CW'(n_reg), a_reg};
                link_re    = 1'b1;
                link_raddr = n_reg;
                state_next = S_LA_WN;
            end

            S_LA_WN:
            begin
                link_we    = 1'b1;
                link_waddr = n_reg;
                link_wdata = {rd_use, rd_next, slot_reg};
                if (new_head_reg)
                begin
                    head_next = slot_reg;
                end
                state_next = S_HKEY;
            end

            S_RM_CHK:
            begin
                if (!rd_use)
                begin
                    status_next = shpq_pkg::ST_BAD;
                    state_next  = S_HKEY;
                end
                else
                begin
                    // Push the slot onto the free list.
                    link_we        = 1'b1;
                    link_waddr     = slot_reg;
                    link_wdata     = {1'b0, free_head_reg, rd_prev};
                    free_head_next = CW'(slot_reg);
                    count_next     = count_reg - CW'(1);
                    p_next         = rd_prev;
                    n_next         = rd_next_idx;
                    if (head_reg == slot_reg)
                    begin
                        head_next = (count_reg > CW'(1)) ? rd_next_idx : '0;
                    end
                    if (count_reg > CW'(1))
                    begin
                        link_re    = 1'b1;
                        link_raddr = rd_prev;
                        state_next = S_RM_WP;
                    end
                    else
                    begin
                        state_next = S_HKEY;
                    end
                end
            end

            S_RM_WP:
            begin
                link_we    = 1'b1;
                link_waddr = p_reg;
                link_wdata = {rd_use, CW'(n_reg), rd_prev};
                state_next = S_RM_RN;
            end

            S_RM_RN:
            begin
                link_re    = 1'b1;
                link_raddr = n_reg;
                state_next = S_RM_WN;
            end

            S_RM_WN:
            begin
                link_we    = 1'b1;
                link_waddr = n_reg;
                link_wdata = {rd_use, rd_next, p_reg};
                state_next = S_HKEY;
            end

            S_HKEY:
            begin
                key_re     = 1'b1;
                key_raddr  = head_reg;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_user_next  = status_reg;
                    m_data_next  = {7'b0, res_cnt, res_hk, res_hh, res_hv, res_nh};
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            free_head_reg <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            new_head_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            free_head_reg <= free_head_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            new_head_reg  <= new_head_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
        cur_reg    <= cur_next;
        tail_reg   <= tail_next;
        a_reg      <= a_next;
        n_reg      <= n_next;
        p_reg      <= p_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

endmodule
